### rtl/core/pctdec_pkg.sv
// Shared types, character codes and hex helper for the percent decoder.
package pctdec_pkg;

   localparam logic [7:0]  CHAR_NUL     = 8'h00;
   localparam logic [7:0]  CHAR_PERCENT = 8'h25;
   localparam logic [7:0]  CHAR_PLUS    = 8'h2B;
   localparam logic [7:0]  CHAR_SPACE   = 8'h20;
   localparam logic [15:0] CAP_RESET    = 16'd256;

   // Work for the back end: up to two decoded bytes, then optionally the terminator.
   typedef struct packed {
      logic [1:0]  nbytes;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic        last;
      logic [15:0] length;
   } cmd_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type r;
      r.valid = 1'b1;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.value = 4'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.value = 4'(c - 8'h61 + 8'd10);
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [7:0] plain_map(input logic [7:0] c);
      return (c == CHAR_PLUS) ? CHAR_SPACE : c;
   endfunction

endpackage

### rtl/core/pctdec_front.sv
// Front end: accepts source bytes, tracks escapes and the output limit, builds commands.
module pctdec_front
   import pctdec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_in_byte,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_out_capacity,
   input  logic        q_full,
   output logic        cmd_push,
   output cmd_type     cmd_data
);

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_PCT,
      PEND_DIGIT
   } pend_type;

   pend_type    pend_ff, pend_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] wcount_ff, wcount_in;
   logic        full_ff, full_in;
   logic [15:0] cap_ff;

   logic [15:0] limit;
   logic        ovf;
   logic        eff_full;
   pend_type    eff_pend;
   logic [15:0] wc_inc;
   logic        accept;
   hex_type     hi_d, lo_d;
   logic [7:0]  hex_byte;

   assign accept   = req_push && !q_full;
   assign limit    = (cap_ff == 16'd0) ? 16'd0 : cap_ff - 16'd1;
   assign ovf      = !full_ff && (wcount_ff >= limit);
   assign eff_full = full_ff || ovf;
   assign eff_pend = ovf ? PEND_NONE : pend_ff;
   assign wc_inc   = wcount_ff + 16'd1;
   assign hi_d     = hex_digit(held_ff);
   assign lo_d     = hex_digit(req_in_byte);

   always_comb begin
      if (!hi_d.valid) begin
         hex_byte = 8'd0;
      end else if (!lo_d.valid) begin
         hex_byte = {4'd0, hi_d.value};
      end else begin
         hex_byte = {hi_d.value, lo_d.value};
      end
   end

   always_comb begin
      pend_in   = pend_ff;
      held_in   = held_ff;
      wcount_in = wcount_ff;
      full_in   = full_ff;
      cmd_push  = 1'b0;
      cmd_data  = '0;
      if (accept) begin
         if (req_in_byte == CHAR_NUL) begin
            cmd_push      = 1'b1;
            cmd_data.last = 1'b1;
            if (!eff_full && eff_pend != PEND_NONE) begin
               cmd_data.byte0  = CHAR_PERCENT;
               cmd_data.nbytes = 2'd1;
               if (eff_pend == PEND_DIGIT && wc_inc < limit) begin
                  cmd_data.byte1  = plain_map(held_ff);
                  cmd_data.nbytes = 2'd2;
               end
            end
            cmd_data.length = wcount_ff + 16'(cmd_data.nbytes);
            pend_in   = PEND_NONE;
            held_in   = 8'd0;
            wcount_in = 16'd0;
            full_in   = 1'b0;
         end else if (eff_full) begin
            full_in = 1'b1;
            pend_in = eff_pend;
         end else begin
            case (eff_pend)
               PEND_NONE: begin
                  if (req_in_byte == CHAR_PERCENT) begin
                     pend_in = PEND_PCT;
                  end else begin
                     cmd_push        = 1'b1;
                     cmd_data.nbytes = 2'd1;
                     cmd_data.byte0  = plain_map(req_in_byte);
                     wcount_in       = wc_inc;
                     full_in         = (wc_inc >= limit);
                  end
               end
               PEND_PCT: begin
                  held_in = req_in_byte;
                  pend_in = PEND_DIGIT;
               end
               PEND_DIGIT: begin
                  cmd_push        = 1'b1;
                  cmd_data.nbytes = 2'd1;
                  cmd_data.byte0  = hex_byte;
                  wcount_in       = wc_inc;
                  full_in         = (wc_inc >= limit);
                  pend_in         = PEND_NONE;
               end
               default: begin
                  pend_in = PEND_NONE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= PEND_NONE;
         held_ff   <= 8'd0;
         wcount_ff <= 16'd0;
         full_ff   <= 1'b0;
         cap_ff    <= CAP_RESET;
      end else begin
         pend_ff   <= pend_in;
         held_ff   <= held_in;
         wcount_ff <= wcount_in;
         full_ff   <= full_in;
         if (csr_wr_en) begin
            cap_ff <= csr_out_capacity;
         end
      end
   end

   // once the limit is hit no escape stays pending
   a_full_no_pend: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> pend_ff == PEND_NONE)
      else $error("pending escape while output full");

   // a terminator restarts the string count
   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && cmd_data.last) |=> (wcount_ff == 16'd0 && !full_ff))
      else $error("state not cleared after terminator");

endmodule

### rtl/core/pctdec_queue.sv
// Short command queue between the front and back ends.
module pctdec_queue
   import pctdec_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into full queue");

endmodule

### rtl/core/pctdec_back.sv
// Back end: expands queued commands into result items behind an output register.
module pctdec_back
   import pctdec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  cmd_type     head_data,
   output logic        head_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic [15:0] rsp_out_length
);

   logic [1:0]  step_ff, step_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [15:0] length_ff, length_in;

   logic [1:0]  pieces;
   logic        final_piece;
   logic        load;

   assign pieces      = head_data.nbytes + {1'b0, head_data.last};
   assign final_piece = (step_ff == pieces - 2'd1);
   assign load        = head_valid && (!valid_ff || rsp_pop);
   assign head_pop    = load && final_piece;

   always_comb begin
      step_in   = step_ff;
      valid_in  = valid_ff && !rsp_pop;
      byte_in   = byte_ff;
      last_in   = last_ff;
      length_in = length_ff;
      if (load) begin
         valid_in = 1'b1;
         step_in  = final_piece ? 2'd0 : step_ff + 2'd1;
         if (step_ff < head_data.nbytes) begin
            byte_in   = (step_ff == 2'd0) ? head_data.byte0 : head_data.byte1;
            last_in   = 1'b0;
            length_in = 16'd0;
         end else begin
            byte_in   = CHAR_NUL;
            last_in   = 1'b1;
            length_in = head_data.length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      length_ff <= length_in;
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_out_last   = last_ff;
   assign rsp_out_length = length_ff;

   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> byte_ff == CHAR_NUL)
      else $error("terminator item carries nonzero byte");

endmodule

### rtl/core/percent_decoder.sv
// Top level of the streaming URL percent decoder.
// Path: an accepted item is written into the command queue; its first result reaches the rsp
// ports through the output register of the back end, which an unpopped output can hold up.
// Throughput: one item per cycle while req_full is low; each item yields at most one result,
// except a terminator after an unfinished escape, which yields up to three, one at a time
// through the single output register of the back end.
// Reset: synchronous; clears all string state and the queue, capacity returns to 256.
module percent_decoder
   import pctdec_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic [15:0] rsp_out_length,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_out_capacity
);

   logic    cmd_push;
   cmd_type cmd_data;
   logic    q_full;
   logic    head_valid;
   cmd_type head_data;
   logic    head_pop;

   assign req_full = q_full;

   pctdec_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_in_byte      (req_in_byte),
      .csr_wr_en        (csr_wr_en),
      .csr_out_capacity (csr_out_capacity),
      .q_full           (q_full),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_data)
   );

   pctdec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_data),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   pctdec_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .head_pop       (head_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .rsp_out_length (rsp_out_length)
   );

endmodule
